### hdl/cdk_pkg.sv
// cdk_pkg: shared types, constants and saturating helpers for the clock
// offset/drift filter. No dependencies; used by cdk_mq and the top level.
`default_nettype none
package cdk_pkg;

    // fixed-point constants
    localparam logic [63:0] INF_VAR    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] C_ONE      = 64'd1;
    localparam logic [63:0] C_2P16     = 64'h0000_0000_0001_0000;
    localparam logic [63:0] C_2P24     = 64'h0000_0000_0100_0000;
    localparam logic [63:0] C_2P32     = 64'h0000_0001_0000_0000;
    localparam logic [63:0] C_2P40     = 64'h0000_0100_0000_0000;
    localparam logic [63:0] C_2P60     = 64'h1000_0000_0000_0000;
    localparam logic [63:0] C_NEG_2P60 = 64'hF000_0000_0000_0000;
    localparam logic [63:0] C_Q8_ONE   = 64'd256;
    localparam logic [63:0] MAX_STEP   = 64'd2097152000;
    localparam logic [63:0] HALF_US    = 64'h0000_0000_0008_0000;

    // op codes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_C2S    = 2'd1;
    localparam logic [1:0] OP_S2C    = 2'd2;

    // status codes
    localparam logic [1:0] STAT_APPLIED  = 2'd0;
    localparam logic [1:0] STAT_SKIPPED  = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;
    localparam logic [1:0] STAT_CONV     = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_ERROR_SCALE   = 3'd0;
    localparam logic [2:0] CFG_FORGET_CUTOFF = 3'd1;
    localparam logic [2:0] CFG_FORGET_FACTOR = 3'd2;
    localparam logic [2:0] CFG_OFFSET_NOISE  = 3'd3;
    localparam logic [2:0] CFG_DRIFT_NOISE   = 3'd4;
    localparam logic [2:0] CFG_DRIFT_SNR     = 3'd5;
    localparam logic [2:0] CFG_WARMUP        = 3'd6;
    localparam logic [2:0] CFG_DRIFT_SAMPLES = 3'd7;

    // register reset values
    localparam logic [15:0] RST_ERROR_SCALE   = 16'd256;
    localparam logic [15:0] RST_FORGET_CUTOFF = 16'd768;
    localparam logic [15:0] RST_FORGET_FACTOR = 16'd256;
    localparam logic [47:0] RST_OFFSET_NOISE  = 48'd429497;
    localparam logic [63:0] RST_DRIFT_NOISE   = 64'd0;
    localparam logic [15:0] RST_DRIFT_SNR     = 16'd1024;
    localparam logic [7:0]  RST_WARMUP        = 8'd100;
    localparam logic [7:0]  RST_DRIFT_SAMPLES = 8'd100;

    typedef enum logic [1:0] {GM_ZERO, GM_TAKE, GM_FUSE} t_gain;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} t_ctl_state;

    typedef enum logic [2:0] {
        MQ_IDLE, MQ_MUL, MQ_NORM, MQ_DIV, MQ_RND, MQ_DONE
    } t_mq_state;

    // sequencer steps
    typedef enum logic [4:0] {
        SP_RV, SP_F1, SP_F1A, SP_F1B, SP_F1C, SP_F1D,
        SP_K1, SP_K2, SP_K3, SP_K4, SP_K5, SP_K6, SP_K7, SP_K8, SP_K9,
        SP_K10, SP_K11, SP_K12, SP_K13, SP_K14, SP_K15, SP_K16, SP_K17,
        SP_K18, SP_K19, SP_KACT, SP_C1, SP_C2
    } t_step;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic       start;
        logic       mul_only;
        logic       neg;
        logic [5:0] sh;
    } t_mq_req;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] from_sm(input logic [63:0] m, input logic neg);
        if (!neg) return m[63] ? S64_MAX : m;
        if (m[63]) return S64_MIN;
        return ~m + 64'd1;
    endfunction

    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic [63:0] sneg(input logic [63:0] a);
        return (a == S64_MIN) ? S64_MAX : (~a + 64'd1);
    endfunction

    function automatic logic [63:0] uadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a == INF_VAR || b == INF_VAR || s[64]) return INF_VAR;
        return s[63:0];
    endfunction

    function automatic logic [63:0] round_us(input logic [63:0] v);
        logic [63:0] m;
        m = mag(v) + HALF_US;
        return from_sm({20'd0, m[63:20]}, v[63]);
    endfunction

    function automatic t_gain gain_mode(input logic [63:0] p, input logic [63:0] r);
        logic [63:0] s;
        s = uadd(p, r);
        if (p == INF_VAR && r != INF_VAR) return GM_TAKE;
        if (s == INF_VAR || s == 64'd0) return GM_ZERO;
        return GM_FUSE;
    endfunction

endpackage
`default_nettype wire

### hdl/cdk_mq.sv
// cdk_mq: shared iterative unit, round(a * b * 2^sh / c) with saturation,
// or the plain 128-bit product a * b. Depends on cdk_pkg.
`default_nettype none
module cdk_mq
    import cdk_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_mq_req       i_req,
    input  wire logic [63:0]   i_a,
    input  wire logic [63:0]   i_b,
    input  wire logic [63:0]   i_c,
    output logic               o_done,
    output logic [63:0]        o_q,
    output logic [63:0]        o_qs,
    output logic [127:0]       o_prod
);

    t_mq_state    r_state, n_state;
    logic [63:0]  r_hi, r_lo, r_b, r_c, r_rem, r_q;
    logic [5:0]   r_cnt, r_sh;
    logic         r_neg, r_mul_only;

    logic [64:0]  w_sum;
    logic [191:0] w_wide;
    logic         w_sat;
    logic [63:0]  w_shl, w_rem_nx;
    logic         w_qbit, w_round;

    // shift-add multiply step
    assign w_sum = r_lo[0] ? ({1'b0, r_hi} + {1'b0, r_b}) : {1'b0, r_hi};

    // scale and overflow check before the divide
    assign w_wide = {64'd0, r_hi, r_lo} << r_sh;
    assign w_sat  = (r_c == 64'd0) || (|w_wide[191:128]) || (w_wide[127:64] >= r_c);

    // restoring divide step
    assign w_shl    = {r_rem[62:0], r_lo[63]};
    assign w_qbit   = r_rem[63] || (w_shl >= r_c);
    assign w_rem_nx = w_qbit ? (w_shl - r_c) : w_shl;

    // round half up
    assign w_round = r_rem >= (r_c - r_rem);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MQ_IDLE: if (i_req.start) n_state = MQ_MUL;
            MQ_MUL:  if (r_cnt == 6'd63) n_state = MQ_NORM;
            MQ_NORM: begin
                if (r_mul_only || w_sat) n_state = MQ_DONE;
                else n_state = MQ_DIV;
            end
            MQ_DIV:  if (r_cnt == 6'd63) n_state = MQ_RND;
            MQ_RND:  n_state = MQ_DONE;
            MQ_DONE: n_state = MQ_IDLE;
            default: n_state = MQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_state == MQ_DONE);
        o_q    = r_q;
        o_qs   = from_sm(r_q, r_neg);
        o_prod = {r_hi, r_lo};
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            MQ_IDLE: begin
                if (i_req.start) begin
                    r_hi       <= 64'd0;
                    r_lo       <= i_a;
                    r_b        <= i_b;
                    r_c        <= i_c;
                    r_sh       <= i_req.sh;
                    r_neg      <= i_req.neg;
                    r_mul_only <= i_req.mul_only;
                    r_cnt      <= 6'd0;
                end
            end
            MQ_MUL: begin
                {r_hi, r_lo} <= {w_sum, r_lo[63:1]};
                r_cnt        <= r_cnt + 6'd1;
            end
            MQ_NORM: begin
                if (!r_mul_only) begin
                    if (w_sat) begin
                        r_q <= INF_VAR;
                    end else begin
                        r_rem <= w_wide[127:64];
                        r_lo  <= w_wide[63:0];
                        r_q   <= 64'd0;
                        r_cnt <= 6'd0;
                    end
                end
            end
            MQ_DIV: begin
                r_rem <= w_rem_nx;
                r_q   <= {r_q[62:0], w_qbit};
                r_lo  <= {r_lo[62:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
            end
            MQ_RND: begin
                if (w_round) r_q <= (r_q == INF_VAR) ? INF_VAR : (r_q + 64'd1);
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### hdl/clock_offset_drift_kalman_top.sv
// clock_offset_drift_kalman_top: two-state offset/drift clock filter with
// time conversion; a step sequencer drives one shared cdk_mq unit.
// Depends on cdk_pkg and cdk_mq.
//
// Usage:
//   s_axis carries one item: op 0 feeds a measurement (offset, error bound,
//   timestamp), op 1 converts client to server time, op 2 the reverse.
//   m_axis returns exactly one result item per input item.
//   The config port writes a register at any clock edge with i_cfg_we high;
//   write only while no item is in flight.
// Flow:
//   one item is in flight at a time; s_axis_tready is high only when idle.
//   Each call of the shared multiply/divide unit runs issue, 64 multiply
//   steps, scale check, 64 divide steps, round and done; a call that
//   saturates in the scale check or only multiplies skips the divide and round.
//   Skipped or unused ops make no call. Conversions: 1 or 2 calls.
//   Measurement updates: 1 to 18 calls, the most for a full filter step
//   with forgetting and drift.
// Reset: synchronous active low; the filter state returns to its empty
//   state (offset variance infinite) and registers to their defaults.
// Stall: a finished result holds on m_axis until taken; no new item is
//   accepted until then.
`default_nettype none
module clock_offset_drift_kalman_top
    import cdk_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // op[1:0], measured_offset[65:2], error_bound[97:66], time_value[161:98]
    input  wire logic [167:0] s_axis_tdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // converted_time[63:0], update_status[65:64], offset_variance[128:66],
    // samples_seen[136:129], drift_in_use[137]
    output logic [143:0]      m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [63:0]  i_cfg_data
);

    // configuration registers
    logic [15:0] r_cfg_scale, r_cfg_cutoff, r_cfg_ffs, r_cfg_snr;
    logic [47:0] r_cfg_onr;
    logic [63:0] r_cfg_dnr;
    logic [7:0]  r_cfg_warm, r_cfg_drift;

    // filter state
    logic [63:0] r_last, n_last, r_off, n_off, r_drift, n_drift;
    logic [63:0] r_pvar, n_pvar, r_cross, n_cross, r_dvar, n_dvar;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_dact, n_dact;

    // item registers
    logic [1:0]  r_op;
    logic [63:0] r_t, r_m20, r_dt;
    logic [31:0] r_e;
    logic [47:0] r_sd;
    logic        r_neg;

    // working registers
    logic [63:0] r_rv, n_rv, r_s, n_s, r_tmp, n_tmp, r_opred, n_opred;
    logic [63:0] r_pf, n_pf, r_qf, n_qf, r_cf, n_cf, r_r, n_r, r_conv, n_conv;
    logic [1:0]  r_status, n_status;
    logic        r_est, n_est;
    t_step       r_pc, n_pc;
    t_ctl_state  r_state, n_state;

    // control
    logic        s_accept, s_direct, s_uses, s_commit, s_finish, w_start;
    logic        w_mul_only, w_uneg;
    logic [5:0]  w_sh;
    logic [63:0] u_a, u_b, u_c;
    t_mq_req     w_req;
    logic        w_done;
    logic [63:0] w_q, w_qs;
    logic [127:0] w_prod;

    // input fields
    logic [1:0]  i_op;
    logic [63:0] i_m, i_t;
    logic [31:0] i_e;
    logic        w_mono, w_tneg;
    logic [63:0] w_m20, w_mmag;

    // helpers
    logic [63:0] w_diff, w_d, w_pf4, w_rk, w_num, w_s1, w_s2, w_cut;
    t_gain       w_g1, w_g2;
    logic [47:0] w_ecut;
    logic [79:0] w_snr;
    logic [48:0] w_var_r;
    logic [62:0] w_var63;

    assign i_op = s_axis_tdata[1:0];
    assign i_m  = s_axis_tdata[65:2];
    assign i_e  = s_axis_tdata[97:66];
    assign i_t  = s_axis_tdata[161:98];

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign w_mono   = $signed(i_t) > $signed(r_last);
    assign w_tneg   = $signed(i_t) < $signed(r_last);

    // measurement scaled to 2^-20 us, saturating
    assign w_mmag = mag(i_m);
    assign w_m20  = (|w_mmag[63:44]) ? from_sm(INF_VAR, i_m[63])
                                     : from_sm({w_mmag[43:0], 20'd0}, i_m[63]);

    assign w_diff = sadd(r_m20, sneg(r_off));
    assign w_d    = r_dact ? r_drift : 64'd0;
    assign w_pf4  = uadd(r_pvar, w_q);
    assign w_rk   = sadd(r_m20, sneg(r_opred));
    assign w_num  = sadd(r_off, r_neg ? sneg(w_qs) : w_qs);
    assign w_g1   = gain_mode(r_pvar, r_rv);
    assign w_s1   = uadd(r_pvar, r_rv);
    assign w_g2   = gain_mode(r_pf, r_rv);
    assign w_s2   = uadd(r_pf, r_rv);
    assign w_ecut = r_e * r_cfg_cutoff;
    assign w_cut  = {4'd0, w_ecut, 12'd0};
    assign w_snr  = r_dvar * r_cfg_snr;

    // steps that run without the shared unit
    always_comb begin
        case (r_pc)
            SP_F1, SP_K8, SP_K10, SP_K14: s_uses = 1'b0;
            default:                      s_uses = 1'b1;
        endcase
    end

    assign s_commit = (r_state == ST_ISSUE && !s_uses) || (r_state == ST_WAIT && w_done);

    // shared unit operands per step
    always_comb begin
        u_a        = 64'd0;
        u_b        = 64'd0;
        u_c        = C_ONE;
        w_mul_only = 1'b0;
        w_uneg     = 1'b0;
        w_sh       = 6'd0;
        unique case (r_pc)
            SP_RV:  begin u_a = {16'd0, r_sd}; u_b = {16'd0, r_sd}; end
            SP_F1A: begin u_a = mag(w_diff); w_uneg = w_diff[63]; u_b = r_pvar; u_c = r_s; end
            SP_F1B: begin u_a = r_pvar; u_b = r_rv; u_c = r_s; end
            SP_F1C: begin u_a = uadd(r_pvar, r_rv); u_b = C_ONE; w_sh = 6'd32; u_c = r_dt; end
            SP_F1D: begin u_a = r_tmp; u_b = C_ONE; w_sh = 6'd32; u_c = r_dt; end
            SP_K1:  begin u_a = mag(r_drift); w_uneg = r_drift[63]; u_b = r_dt; u_c = C_2P40; end
            SP_K2:  begin u_a = r_dt; u_b = r_cfg_dnr; u_c = C_2P16; end
            SP_K3:  begin u_a = r_dvar; u_b = r_dt; u_c = C_2P40; end
            SP_K4:  begin u_a = r_dt; u_b = {16'd0, r_cfg_onr}; u_c = C_2P16; end
            SP_K5:  begin u_a = r_dvar; u_b = r_dt; u_c = C_2P32; end
            SP_K6:  begin u_a = r_tmp; u_b = r_dt; u_c = C_2P32; end
            SP_K7:  begin u_a = mag(r_cross); u_b = r_dt; w_sh = 6'd1; u_c = C_2P24; end
            SP_K9, SP_K15: begin
                u_a = mag(r_r); w_uneg = r_r[63]; u_b = r_pf; u_c = r_s;
            end
            SP_K11: begin u_a = r_pf; u_b = {48'd0, r_cfg_ffs}; u_c = C_Q8_ONE; end
            SP_K12: begin u_a = r_qf; u_b = {48'd0, r_cfg_ffs}; u_c = C_Q8_ONE; end
            SP_K13: begin
                u_a = mag(r_cf); w_uneg = r_cf[63]; u_b = {48'd0, r_cfg_ffs}; u_c = C_Q8_ONE;
            end
            SP_K16: begin
                u_a = mag(r_r); w_uneg = r_r[63]; u_b = mag(r_cf); w_sh = 6'd16; u_c = r_s;
            end
            SP_K17: begin u_a = mag(r_cf); u_b = mag(r_cf); w_sh = 6'd16; u_c = r_s; end
            SP_K18: begin u_a = mag(r_cf); w_uneg = r_cf[63]; u_b = r_rv; u_c = r_s; end
            SP_K19: begin u_a = r_pf; u_b = r_rv; u_c = r_s; end
            SP_KACT: begin u_a = mag(r_drift); u_b = mag(r_drift); w_mul_only = 1'b1; end
            SP_C1:  begin u_a = mag(w_d); w_uneg = w_d[63]; u_b = r_dt; u_c = C_2P40; end
            SP_C2:  begin
                u_a = mag(r_r); w_uneg = r_r[63]; u_b = C_2P60; u_c = C_2P60 + w_d;
            end
            default: ;
        endcase
    end

    assign w_req = '{start: w_start, mul_only: w_mul_only, neg: w_uneg, sh: w_sh};

    cdk_mq u_mq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (u_a),
        .i_b     (u_b),
        .i_c     (u_c),
        .o_done  (w_done),
        .o_q     (w_q),
        .o_qs    (w_qs),
        .o_prod  (w_prod)
    );

    // step results and item dispatch
    always_comb begin
        n_last = r_last;  n_off = r_off;    n_drift = r_drift; n_pvar = r_pvar;
        n_cross = r_cross; n_dvar = r_dvar; n_cnt = r_cnt;     n_dact = r_dact;
        n_rv = r_rv;      n_s = r_s;        n_tmp = r_tmp;     n_opred = r_opred;
        n_pf = r_pf;      n_qf = r_qf;      n_cf = r_cf;       n_r = r_r;
        n_conv = r_conv;  n_status = r_status; n_est = r_est;  n_pc = r_pc;
        s_finish = 1'b0;
        s_direct = 1'b1;
        if (r_state == ST_IDLE && s_accept) begin
            n_conv   = 64'd0;
            n_status = STAT_SKIPPED;
            case (i_op)
                OP_UPDATE: begin
                    if (w_mono) begin
                        n_pc = SP_RV; n_status = STAT_APPLIED; s_direct = 1'b0;
                    end
                end
                OP_C2S, OP_S2C: begin
                    n_pc = SP_C1; n_status = STAT_CONV; s_direct = 1'b0;
                end
                default: ;
            endcase
        end else if (s_commit) begin
            unique case (r_pc)
                SP_RV: begin
                    n_rv = w_q; n_last = r_t; n_est = (r_cnt >= r_cfg_drift);
                    if (r_cnt == 8'd0) begin
                        n_cnt = 8'd1; n_off = r_m20; n_pvar = w_q; n_drift = 64'd0;
                        s_finish = 1'b1;
                    end else if (r_cnt == 8'd1) begin
                        n_pc = SP_F1;
                    end else begin
                        n_pc = SP_K1;
                    end
                end
                // second sample fuses with the seed, replaces it or keeps it, by gain mode
                SP_F1: begin
                    n_cnt = 8'd2; n_drift = 64'd0; n_cross = 64'd0; n_s = w_s1;
                    n_pc = SP_F1C;
                    if (w_g1 == GM_TAKE) begin
                        n_off = r_m20; n_pvar = r_rv;
                    end else if (w_g1 == GM_FUSE) begin
                        n_pc = SP_F1A;
                    end
                end
                SP_F1A: begin n_off = sadd(r_off, w_qs); n_pc = SP_F1B; end
                SP_F1B: begin n_pvar = w_q; n_pc = SP_F1C; end
                SP_F1C: begin n_tmp = w_q; n_pc = SP_F1D; end
                SP_F1D: begin n_dvar = w_q; s_finish = 1'b1; end
                // predict
                SP_K1: begin
                    n_opred = sadd(r_off, w_qs); n_qf = 64'd0; n_cf = 64'd0;
                    n_pc = r_est ? SP_K2 : SP_K4;
                end
                SP_K2: begin n_qf = uadd(r_dvar, w_q); n_pc = SP_K3; end
                SP_K3: begin n_cf = sadd(r_cross, from_sm(w_q, 1'b0)); n_pc = SP_K4; end
                SP_K4: begin
                    n_pf = w_pf4;
                    n_pc = (r_est && w_pf4 != INF_VAR) ? SP_K5 : SP_K8;
                end
                SP_K5: begin n_tmp = w_q; n_pc = SP_K6; end
                SP_K6: begin n_pf = uadd(r_pf, w_q); n_pc = SP_K7; end
                SP_K7: begin
                    if (!r_cross[63]) n_pf = uadd(r_pf, w_q);
                    else if (r_pf != INF_VAR) n_pf = (r_pf > w_q) ? (r_pf - w_q) : 64'd0;
                    n_pc = SP_K8;
                end
                // step size check
                SP_K8: begin
                    n_r = w_rk; n_s = w_s2; n_pc = SP_K10;
                    if (w_g2 == GM_TAKE) begin
                        if (mag(w_rk) > MAX_STEP) begin
                            n_status = STAT_REJECTED; s_finish = 1'b1;
                        end
                    end else if (w_g2 == GM_FUSE) begin
                        n_pc = SP_K9;
                    end
                end
                SP_K9: begin
                    if (mag(w_qs) > MAX_STEP) begin
                        n_status = STAT_REJECTED; s_finish = 1'b1;
                    end else begin
                        n_pc = SP_K10;
                    end
                end
                // warmup count or forgetting on a large residual
                SP_K10: begin
                    if (r_cnt < r_cfg_warm) begin
                        n_cnt = r_cnt + 8'd1; n_pc = SP_K14;
                    end else if (mag(r_r) > w_cut) begin
                        n_pc = SP_K11;
                    end else begin
                        n_pc = SP_K14;
                    end
                end
                SP_K11: begin
                    if (r_pf != INF_VAR) n_pf = w_q;
                    n_pc = SP_K12;
                end
                SP_K12: begin n_qf = w_q; n_pc = SP_K13; end
                SP_K13: begin n_cf = w_qs; n_pc = SP_K14; end
                // update
                SP_K14: begin
                    n_s = w_s2; n_pc = SP_KACT;
                    if (w_g2 == GM_TAKE) begin
                        n_off = r_m20; n_pvar = r_rv; n_cross = 64'd0; n_dvar = r_qf;
                    end else if (w_g2 == GM_ZERO) begin
                        n_off = r_opred; n_pvar = r_pf; n_cross = r_cf; n_dvar = r_qf;
                    end else begin
                        n_pc = SP_K15;
                    end
                end
                SP_K15: begin
                    n_off = sadd(r_opred, w_qs); n_pc = r_est ? SP_K16 : SP_K17;
                end
                SP_K16: begin
                    n_drift = sadd(r_drift, r_cf[63] ? sneg(w_qs) : w_qs); n_pc = SP_K17;
                end
                SP_K17: begin
                    n_dvar = (r_qf > w_q) ? (r_qf - w_q) : 64'd0; n_pc = SP_K18;
                end
                SP_K18: begin n_cross = w_qs; n_pc = SP_K19; end
                SP_K19: begin n_pvar = w_q; n_pc = SP_KACT; end
                // drift significance
                SP_KACT: begin
                    n_dact = (r_cnt >= r_cfg_drift) && (w_prod > {16'd0, w_snr, 32'd0});
                    s_finish = 1'b1;
                end
                // conversions
                SP_C1: begin
                    n_r = w_num;
                    if (r_op == OP_C2S) begin
                        n_conv = sadd(r_t, round_us(w_num)); s_finish = 1'b1;
                    end else if ($signed(w_d) > $signed(C_NEG_2P60)) begin
                        n_pc = SP_C2;
                    end else begin
                        n_conv = sadd(r_t, sneg(round_us(r_off))); s_finish = 1'b1;
                    end
                end
                SP_C2: begin
                    n_conv = sadd(r_t, sneg(round_us(w_qs))); s_finish = 1'b1;
                end
                default: s_finish = 1'b1;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_accept) n_state = s_direct ? ST_OUT : ST_ISSUE;
            ST_ISSUE: begin
                if (s_uses) n_state = ST_WAIT;
                else if (s_finish) n_state = ST_OUT;
            end
            ST_WAIT:  if (w_done) n_state = s_finish ? ST_OUT : ST_ISSUE;
            ST_OUT:   if (m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_OUT);
        w_start       = (r_state == ST_ISSUE) && s_uses;
    end

    // result item
    assign w_var_r = {1'b0, r_pvar[63:16]} + {48'd0, r_pvar[15]};
    assign w_var63 = (r_pvar == INF_VAR) ? {63{1'b1}} : {14'd0, w_var_r};
    assign m_axis_tdata = {6'd0, r_dact, r_cnt, w_var63, r_status, r_conv};

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= SP_RV;
            r_last  <= 64'd0;
            r_off   <= 64'd0;
            r_drift <= 64'd0;
            r_pvar  <= INF_VAR;
            r_cross <= 64'd0;
            r_dvar  <= 64'd0;
            r_cnt   <= 8'd0;
            r_dact  <= 1'b0;
            r_cfg_scale  <= RST_ERROR_SCALE;
            r_cfg_cutoff <= RST_FORGET_CUTOFF;
            r_cfg_ffs    <= RST_FORGET_FACTOR;
            r_cfg_onr    <= RST_OFFSET_NOISE;
            r_cfg_dnr    <= RST_DRIFT_NOISE;
            r_cfg_snr    <= RST_DRIFT_SNR;
            r_cfg_warm   <= RST_WARMUP;
            r_cfg_drift  <= RST_DRIFT_SAMPLES;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_last  <= n_last;
            r_off   <= n_off;
            r_drift <= n_drift;
            r_pvar  <= n_pvar;
            r_cross <= n_cross;
            r_dvar  <= n_dvar;
            r_cnt   <= n_cnt;
            r_dact  <= n_dact;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ERROR_SCALE:   r_cfg_scale  <= i_cfg_data[15:0];
                    CFG_FORGET_CUTOFF: r_cfg_cutoff <= i_cfg_data[15:0];
                    CFG_FORGET_FACTOR: r_cfg_ffs    <= i_cfg_data[15:0];
                    CFG_OFFSET_NOISE:  r_cfg_onr    <= i_cfg_data[47:0];
                    CFG_DRIFT_NOISE:   r_cfg_dnr    <= i_cfg_data;
                    CFG_DRIFT_SNR:     r_cfg_snr    <= i_cfg_data[15:0];
                    CFG_WARMUP:        r_cfg_warm   <= i_cfg_data[7:0];
                    CFG_DRIFT_SAMPLES: r_cfg_drift  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_rv <= n_rv;   r_s <= n_s;     r_tmp <= n_tmp; r_opred <= n_opred;
        r_pf <= n_pf;   r_qf <= n_qf;   r_cf <= n_cf;   r_r <= n_r;
        r_conv <= n_conv; r_status <= n_status; r_est <= n_est;
        if (s_accept) begin
            r_op  <= i_op;
            r_t   <= i_t;
            r_e   <= i_e;
            r_m20 <= w_m20;
            r_sd  <= i_e * r_cfg_scale;
            r_neg <= w_tneg;
            r_dt  <= w_tneg ? (r_last - i_t) : (i_t - r_last);
        end
    end

    // both channels never open at once
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output open together");

    // an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready after accept");

    // only measurement updates can be rejected
    a_reject_is_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == STAT_REJECTED) |-> (r_op == OP_UPDATE))
        else $error("reject on a conversion");

    // the sample count never falls back to zero without reset
    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 8'd0) |=> (r_cnt != 8'd0))
        else $error("sample count cleared");

endmodule
`default_nettype wire

### dv/tb_clock_offset_drift_kalman_top.sv
// tb_clock_offset_drift_kalman_top: self-checking testbench for the clock
// offset/drift filter; an in-bench fixed-point filter model predicts each result.
// Depends on cdk_pkg and clock_offset_drift_kalman_top.
`timescale 1ns / 1ps
module tb_clock_offset_drift_kalman_top;
    import cdk_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam longint     CYCLE_LIMIT = 40_000_000;
    localparam longint     T_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint     T_MIN       = 64'sh8000_0000_0000_0000;

    // result item, lowest field last
    typedef struct packed {
        logic        drift_on;
        logic [7:0]  count;
        logic [62:0] var_us;
        logic [1:0]  status;
        logic [63:0] conv_time;
    } t_report;

    logic         i_clk;
    logic         i_rst_n;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [63:0]  i_cfg_data;

    clock_offset_drift_kalman_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // filter model configuration
    logic [15:0] cfg_scale, cfg_cutoff, cfg_forget, cfg_snr;
    logic [47:0] cfg_onoise;
    logic [63:0] cfg_dnoise;
    logic [7:0]  cfg_warmup, cfg_dsamples;

    // filter model state
    logic [63:0] flt_stamp, flt_offset, flt_drift, flt_cross, flt_ovar, flt_dvar;
    logic [7:0]  flt_count;
    logic        flt_active;

    t_report     filter_reports_q[$];
    int          send_idle_pct, recv_idle_pct;
    int          mismatches = 0;
    int          reports_checked = 0;
    int          updates_sent, convs_sent;
    longint      cycles = 0;
    // stimulus timeline
    longint      stamp_now, true_offset;
    int          drift_ppm;

    // ---------------- fixed-point arithmetic ----------------

    // round(a*b*2^sh/c) to nearest, saturating to all ones
    function automatic logic [63:0] muldiv(input logic [63:0] a, input logic [63:0] b,
                                           input int sh, input logic [63:0] c);
        logic [127:0] p, q, r;
        if (c == 64'd0) return INF_VAR;
        p = {64'd0, a} * {64'd0, b};
        if (sh != 0 && (p >> (128 - sh)) != 128'd0) return INF_VAR;
        p = p << sh;
        if (p[127:64] >= c) return INF_VAR;
        q = p / {64'd0, c};
        r = p % {64'd0, c};
        if (r[63:0] >= c - r[63:0]) begin
            if (q[63:0] == INF_VAR) return INF_VAR;
            q = q + 128'd1;
        end
        return q[63:0];
    endfunction

    function automatic logic [63:0] abs_of(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] signed_sat(input logic [63:0] m, input logic neg);
        if (!neg) return m[63] ? S64_MAX : m;
        if (m[63]) return S64_MIN;
        return 64'd0 - m;
    endfunction

    function automatic logic [63:0] smuldiv(input logic [63:0] a, input logic [63:0] b,
                                            input int sh, input logic [63:0] c);
        return signed_sat(muldiv(abs_of(a), b, sh, c), a[63]);
    endfunction

    function automatic logic [63:0] add_s(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] w;
        w = {a[63], a} + {b[63], b};
        if (w[64] != w[63]) return w[64] ? S64_MIN : S64_MAX;
        return w[63:0];
    endfunction

    function automatic logic [63:0] neg_s(input logic [63:0] a);
        return (a == S64_MIN) ? S64_MAX : (64'd0 - a);
    endfunction

    function automatic logic [63:0] add_u(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] w;
        w = {1'b0, a} + {1'b0, b};
        if (a == INF_VAR || b == INF_VAR || w[64]) return INF_VAR;
        return w[63:0];
    endfunction

    function automatic logic [63:0] to_us(input logic [63:0] v);
        logic [63:0] m;
        m = abs_of(v) + HALF_US;
        return signed_sat(m >> 20, v[63]);
    endfunction

    function automatic t_gain fusion_kind(input logic [63:0] p, input logic [63:0] r,
                                          output logic [63:0] s);
        s = add_u(p, r);
        if (p == INF_VAR && r != INF_VAR) return GM_TAKE;
        if (s == INF_VAR || s == 64'd0) return GM_ZERO;
        return GM_FUSE;
    endfunction

    // ---------------- filter model ----------------

    // predict/update for the third and later samples
    function automatic logic [1:0] kalman_update(input logic [63:0] m20, input logic [63:0] e,
                                                 input logic [63:0] dt, input logic [63:0] rv);
        logic         est;
        logic [63:0]  opred, pf, qf, s, t, cf, r, adj, d, dm;
        logic [127:0] lhs, rhs;
        t_gain        kind;
        est   = flt_count >= cfg_dsamples;
        opred = add_s(flt_offset, smuldiv(flt_drift, dt, 0, C_2P40));
        qf    = 64'd0;
        cf    = 64'd0;
        if (est) begin
            qf = add_u(flt_dvar, muldiv(dt, cfg_dnoise, 0, C_2P16));
            cf = add_s(flt_cross, signed_sat(muldiv(flt_dvar, dt, 0, C_2P40), 1'b0));
        end
        pf = add_u(flt_ovar, muldiv(dt, {16'd0, cfg_onoise}, 0, C_2P16));
        if (est && pf != INF_VAR) begin
            pf = add_u(pf, muldiv(muldiv(flt_dvar, dt, 0, C_2P32), dt, 0, C_2P32));
            t  = muldiv(abs_of(flt_cross), dt, 1, C_2P24);
            if (!flt_cross[63]) pf = add_u(pf, t);
            else if (pf != INF_VAR) pf = (pf > t) ? pf - t : 64'd0;
        end

        // prospective step limit
        r    = add_s(m20, neg_s(opred));
        kind = fusion_kind(pf, rv, s);
        adj  = (kind == GM_TAKE) ? r : ((kind == GM_FUSE) ? smuldiv(r, pf, 0, s) : 64'd0);
        if (abs_of(adj) > MAX_STEP) return STAT_REJECTED;

        // warmup count or forgetting on a large residual
        if (flt_count < cfg_warmup) begin
            flt_count = flt_count + 8'd1;
        end else if (abs_of(r) > ((e * {48'd0, cfg_cutoff}) << 12)) begin
            if (pf != INF_VAR) pf = muldiv(pf, {48'd0, cfg_forget}, 0, C_Q8_ONE);
            qf = muldiv(qf, {48'd0, cfg_forget}, 0, C_Q8_ONE);
            cf = smuldiv(cf, {48'd0, cfg_forget}, 0, C_Q8_ONE);
        end

        kind = fusion_kind(pf, rv, s);
        if (kind == GM_TAKE) begin
            flt_offset = m20; flt_ovar = rv; flt_cross = 64'd0; flt_dvar = qf;
        end else if (kind == GM_ZERO) begin
            flt_offset = opred; flt_ovar = pf; flt_cross = cf; flt_dvar = qf;
        end else begin
            flt_offset = add_s(opred, smuldiv(r, pf, 0, s));
            if (est) begin
                d = smuldiv(r, abs_of(cf), 16, s);
                flt_drift = add_s(flt_drift, cf[63] ? neg_s(d) : d);
            end
            t         = muldiv(abs_of(cf), abs_of(cf), 16, s);
            flt_dvar  = (qf > t) ? qf - t : 64'd0;
            flt_cross = smuldiv(cf, rv, 0, s);
            flt_ovar  = muldiv(pf, rv, 0, s);
        end

        // drift significance
        dm  = abs_of(flt_drift);
        lhs = {64'd0, dm} * {64'd0, dm};
        rhs = ({64'd0, flt_dvar} * {112'd0, cfg_snr}) << 32;
        flt_active = (flt_count >= cfg_dsamples) && (lhs > rhs);
        return STAT_APPLIED;
    endfunction

    // one input item through the model
    function automatic t_report filter_predict(input logic [1:0] op, input logic [63:0] m,
                                               input logic [31:0] e, input logic [63:0] t);
        t_report     rep;
        logic [63:0] dt, sd, rv, s, m20, span, d, delta, num;
        logic        back;
        t_gain       kind;
        rep.conv_time = 64'd0;
        rep.status    = STAT_SKIPPED;
        if (op == OP_UPDATE) begin
            if ($signed(t) > $signed(flt_stamp)) begin
                dt  = t - flt_stamp;
                sd  = {32'd0, e} * {48'd0, cfg_scale};
                rv  = muldiv(sd, sd, 0, C_ONE);
                m20 = smuldiv(m, C_ONE, 20, C_ONE);
                flt_stamp  = t;
                rep.status = STAT_APPLIED;
                if (flt_count == 8'd0) begin
                    flt_count = 8'd1; flt_offset = m20; flt_ovar = rv; flt_drift = 64'd0;
                end else if (flt_count == 8'd1) begin
                    kind = fusion_kind(flt_ovar, rv, s);
                    flt_count = 8'd2;
                    if (kind == GM_TAKE) begin
                        flt_offset = m20; flt_ovar = rv;
                    end else if (kind == GM_FUSE) begin
                        flt_offset = add_s(flt_offset,
                            smuldiv(add_s(m20, neg_s(flt_offset)), flt_ovar, 0, s));
                        flt_ovar = muldiv(flt_ovar, rv, 0, s);
                    end
                    flt_drift = 64'd0;
                    flt_cross = 64'd0;
                    flt_dvar  = muldiv(muldiv(add_u(flt_ovar, rv), C_ONE, 32, dt),
                                       C_ONE, 32, dt);
                end else begin
                    rep.status = kalman_update(m20, {32'd0, e}, dt, rv);
                end
            end
        end else if (op == OP_C2S || op == OP_S2C) begin
            back  = $signed(t) < $signed(flt_stamp);
            span  = back ? flt_stamp - t : t - flt_stamp;
            d     = flt_active ? flt_drift : 64'd0;
            delta = smuldiv(d, span, 0, C_2P40);
            num   = add_s(flt_offset, back ? neg_s(delta) : delta);
            rep.status = STAT_CONV;
            if (op == OP_C2S)
                rep.conv_time = add_s(t, to_us(num));
            else if ($signed(d) > $signed(C_NEG_2P60))
                rep.conv_time = add_s(t, neg_s(to_us(smuldiv(num, C_2P60, 0, C_2P60 + d))));
            else
                rep.conv_time = add_s(t, neg_s(to_us(flt_offset)));
        end
        rep.var_us   = (flt_ovar == INF_VAR) ? S64_MAX[62:0]
                                             : 63'((flt_ovar >> 16) + ((flt_ovar >> 15) & 64'd1));
        rep.count    = flt_count;
        rep.drift_on = flt_active;
        return rep;
    endfunction

    // ---------------- drivers ----------------

    // one item on the input stream; model runs in acceptance order
    task automatic send_item(input logic [1:0] op, input longint m, input logic [31:0] e,
                             input longint t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tdata  <= {6'd0, t, e, m, op};
        s_axis_tvalid <= 1'b1;
        filter_reports_q.push_back(filter_predict(op, m, e, t));
        if (op == OP_UPDATE) updates_sent++;
        else convs_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drain, let the block settle, then write one register
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        s_axis_tvalid <= 1'b0;
        while (filter_reports_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ERROR_SCALE:   cfg_scale    = data[15:0];
            CFG_FORGET_CUTOFF: cfg_cutoff   = data[15:0];
            CFG_FORGET_FACTOR: cfg_forget   = data[15:0];
            CFG_OFFSET_NOISE:  cfg_onoise   = data[47:0];
            CFG_DRIFT_NOISE:   cfg_dnoise   = data;
            CFG_DRIFT_SNR:     cfg_snr      = data[15:0];
            CFG_WARMUP:        cfg_warmup   = data[7:0];
            default:           cfg_dsamples = data[7:0];
        endcase
    endtask

    task automatic write_all(input logic [15:0] scale, input logic [15:0] cutoff,
                             input logic [15:0] forget, input logic [47:0] onoise,
                             input logic [63:0] dnoise, input logic [15:0] snr,
                             input logic [7:0] warmup, input logic [7:0] dsamples);
        write_reg(CFG_ERROR_SCALE, {48'd0, scale});
        write_reg(CFG_FORGET_CUTOFF, {48'd0, cutoff});
        write_reg(CFG_FORGET_FACTOR, {48'd0, forget});
        write_reg(CFG_OFFSET_NOISE, {16'd0, onoise});
        write_reg(CFG_DRIFT_NOISE, dnoise);
        write_reg(CFG_DRIFT_SNR, {48'd0, snr});
        write_reg(CFG_WARMUP, {56'd0, warmup});
        write_reg(CFG_DRIFT_SAMPLES, {56'd0, dsamples});
    endtask

    function automatic longint rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ---------------- tests ----------------

    // extremes, every op and the named corner cases, default registers
    task automatic test_directed();
        send_item(OP_C2S, 0, 0, 1000);                         // empty filter
        send_item(OP_S2C, 0, 0, T_MIN);
        send_item(OP_UNUSED, rand64(), $urandom(), rand64());
        send_item(OP_UPDATE, 7, 5, 0);                         // stamp not above reset
        send_item(OP_UPDATE, 5000, 100, 1_000_000);            // seed
        send_item(OP_UPDATE, 5010, 50, 2_000_000);             // fusion
        send_item(OP_UPDATE, 5020, 0, 3_000_000);              // zero measurement noise
        send_item(OP_UPDATE, T_MAX, 10, 4_000_000);            // huge step, rejected
        send_item(OP_UPDATE, T_MIN, 32'hFFFF_FFFF, 5_000_000); // infinite noise
        send_item(OP_UPDATE, 5030, 20, 4_500_000);             // going backwards
        send_item(OP_UPDATE, 5030, 20, 5_000_000);             // equal stamp
        send_item(OP_C2S, 0, 0, T_MAX);
        send_item(OP_C2S, 0, 0, T_MIN);
        send_item(OP_S2C, 0, 0, T_MAX);
        send_item(OP_S2C, 0, 0, 123_456);
        send_item(OP_UPDATE, -3000, 1, 6_000_000);
        send_item(OP_UPDATE, 5040, 32'hFFFF_FFFF, 7_000_000);
        send_item(OP_UNUSED, 0, 0, 0);
        send_item(OP_C2S, rand64(), $urandom(), 7_000_000);
        stamp_now   = 7_000_000;
        true_offset = 5040;
    endtask

    // a measurement stream with conversions and some noise, mixed with unused ops, stale or random items and outliers
    task automatic random_items(input int n);
        int     sel, eb;
        longint step, noise;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                step = ($urandom_range(9) == 0) ? 1 : $urandom_range(2_000_000, 1);
                stamp_now   += step;
                true_offset += (step * drift_ppm) / 1_000_000;
                eb    = $urandom_range(3) == 0 ? $urandom_range(20) : $urandom_range(5000);
                noise = longint'($urandom_range(2 * eb)) - longint'(eb);
                send_item(OP_UPDATE, true_offset + noise, eb, stamp_now);
            end else if (sel < 88) begin
                send_item($urandom_range(1) ? OP_C2S : OP_S2C, rand64(), $urandom(),
                          stamp_now + $signed($urandom_range(20_000_000)) - 10_000_000);
            end else begin
                case ($urandom_range(4))
                    0: send_item(OP_UNUSED, rand64(), $urandom(), rand64());
                    1: send_item(OP_UPDATE, rand64(), $urandom(),
                                 stamp_now - $urandom_range(1_000_000));
                    2: send_item($urandom_range(1) ? OP_C2S : OP_S2C, rand64(), $urandom(),
                                 rand64());
                    3: begin
                        stamp_now += $urandom_range(3_000_000, 1);
                        send_item(OP_UPDATE, rand64(), $urandom(), stamp_now);
                    end
                    default: begin
                        // outlier, well past the cutoff in all but the high-extremes settings
                        stamp_now += $urandom_range(1_000_000, 1);
                        send_item(OP_UPDATE, true_offset + $urandom_range(1500, 300), 10,
                                  stamp_now);
                    end
                endcase
            end
        end
    endtask

    task automatic test_defaults();
        send_idle_pct = 33; recv_idle_pct = 87; drift_ppm = 37;
        random_items(360);
    endtask

    task automatic test_low_extremes();
        write_all(16'd0, 16'd0, 16'd65535, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  16'd0, 8'd0, 8'd0);
        send_idle_pct = 87; recv_idle_pct = 33; drift_ppm = -150;
        random_items(220);
    endtask

    task automatic test_high_extremes();
        write_all(16'd65535, 16'd65535, 16'd0, 48'd0, 64'd0, 16'd65535, 8'd255, 8'd255);
        random_items(180);
    endtask

    task automatic test_tuned();
        write_all(16'd256, 16'd512, 16'd512, 48'd429497, 64'd4_000_000, 16'd16, 8'd4, 8'd8);
        send_idle_pct = 0; recv_idle_pct = 0; drift_ppm = 120;
        random_items(470);
    endtask

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_report got, want;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[137:0];
            if (filter_reports_q.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                mismatches++;
            end else begin
                want = filter_reports_q.pop_front();
                reports_checked++;
                if (got.conv_time != want.conv_time) begin
                    $error("converted_time expected %0d got %0d",
                           $signed(want.conv_time), $signed(got.conv_time));
                    mismatches++;
                end
                if (got.status != want.status) begin
                    $error("update_status expected %0d got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.var_us != want.var_us) begin
                    $error("offset_variance expected %0d got %0d", want.var_us, got.var_us);
                    mismatches++;
                end
                if (got.count != want.count) begin
                    $error("samples_seen expected %0d got %0d", want.count, got.count);
                    mismatches++;
                end
                if (got.drift_on != want.drift_on) begin
                    $error("drift_in_use expected %0d got %0d", want.drift_on, got.drift_on);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL clock_offset_drift_kalman_top");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        updates_sent = 0; convs_sent = 0;
        send_idle_pct = 33; recv_idle_pct = 87;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        cfg_scale = RST_ERROR_SCALE; cfg_cutoff = RST_FORGET_CUTOFF;
        cfg_forget = RST_FORGET_FACTOR; cfg_onoise = RST_OFFSET_NOISE;
        cfg_dnoise = RST_DRIFT_NOISE; cfg_snr = RST_DRIFT_SNR;
        cfg_warmup = RST_WARMUP; cfg_dsamples = RST_DRIFT_SAMPLES;
        flt_stamp = 0; flt_offset = 0; flt_drift = 0; flt_cross = 0;
        flt_ovar = INF_VAR; flt_dvar = 0; flt_count = 0; flt_active = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_defaults();
        test_low_extremes();
        test_high_extremes();
        test_tuned();

        s_axis_tvalid <= 1'b0;
        while (filter_reports_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d measurement and %0d conversion/unused items, %0d results checked",
                 updates_sent, convs_sent, reports_checked);
        $display("four register settings incl. both extremes, sender/receiver stalls swapped");
        if (mismatches == 0) begin
            $display("PASS clock_offset_drift_kalman_top");
        end else begin
            $display("FAIL clock_offset_drift_kalman_top");
        end
        $finish;
    end

endmodule

### sim.f
hdl/cdk_pkg.sv
hdl/cdk_mq.sv
hdl/clock_offset_drift_kalman_top.sv
dv/tb_clock_offset_drift_kalman_top.sv
